/* rtl/linear_probe_hash_table_assert.svh */
// ============================================================================
// linear_probe_hash_table_assert.svh
// Assertion macros shared by the hash table checker.
// ============================================================================
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define LPHT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define LPHT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/lpht_pkg.sv */
// ============================================================================
// lpht_pkg
// Shared types and constants of the linear probing hash table.
// ============================================================================
`default_nettype none

package lpht_pkg;

   // Default slot count
   localparam int SLOTS_DEFAULT = 16;

   // Key and result field widths
   localparam int KEY_W   = 32;
   localparam int INDEX_W = 4;

   // Request opcodes
   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_SEARCH = 1'b1
   } opcode_type;

   // Result status codes
   typedef enum logic [1:0] {
      RSP_INSERTED  = 2'd0,
      RSP_FULL      = 2'd1,
      RSP_FOUND     = 2'd2,
      RSP_NOT_FOUND = 2'd3
   } rsp_status_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH1,
      ST_HASH2,
      ST_HASH3,
      ST_PROBE
   } ctrl_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic clear_we;
      logic load;
      logic hash_mul;
      logic hash_red;
      logic probe_start;
      logic probe_step;
      logic finish;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic probe_end;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

/* rtl/lpht_ctrl.sv */
// ============================================================================
// lpht_ctrl
// Sequencer for the hash table: clear pass, hash steps and probe walk.
// ============================================================================
`default_nettype none

module lpht_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire lpht_pkg::sts_type sts,
   output lpht_pkg::cmd_type     cmd
);

   lpht_pkg::ctrl_state_type state_ff;
   lpht_pkg::ctrl_state_type state_in;

   // Hold state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpht_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Pick next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lpht_pkg::ST_CLEAR: begin
            if (sts.clear_last) state_in = lpht_pkg::ST_IDLE;
         end
         lpht_pkg::ST_IDLE: begin
            if (req_valid) state_in = lpht_pkg::ST_HASH1;
         end
         lpht_pkg::ST_HASH1: state_in = lpht_pkg::ST_HASH2;
         lpht_pkg::ST_HASH2: state_in = lpht_pkg::ST_HASH3;
         lpht_pkg::ST_HASH3: state_in = lpht_pkg::ST_PROBE;
         lpht_pkg::ST_PROBE: begin
            if (sts.out_free && sts.probe_end) state_in = lpht_pkg::ST_IDLE;
         end
         default: state_in = lpht_pkg::ST_CLEAR;
      endcase
   end

   // Drive commands and request stall
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         lpht_pkg::ST_CLEAR: cmd.clear_we = 1'b1;
         lpht_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         lpht_pkg::ST_HASH1: cmd.hash_mul    = 1'b1;
         lpht_pkg::ST_HASH2: cmd.hash_red    = 1'b1;
         lpht_pkg::ST_HASH3: cmd.probe_start = 1'b1;
         lpht_pkg::ST_PROBE: begin
            if (sts.out_free) begin
               cmd.finish     = sts.probe_end;
               cmd.probe_step = !sts.probe_end;
            end
         end
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

/* rtl/lpht_dpath.sv */
// ============================================================================
// lpht_dpath
// Slot memory, modulo hash by reciprocal multiply, probe pointer and
// result register of the hash table.
// ============================================================================
`default_nettype none

module lpht_dpath #(
   parameter int SLOTS = lpht_pkg::SLOTS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lpht_pkg::cmd_type             cmd,
   output lpht_pkg::sts_type                  sts,
   input  wire logic                          req_opcode,
   input  wire logic [lpht_pkg::KEY_W-1:0]    req_key,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic [lpht_pkg::INDEX_W-1:0]       rsp_slot_index
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int SHIFT = 31 + IDX_W;
   // floor(2^SHIFT / SLOTS) fits in 32 bits for every slot count
   localparam logic [63:0] RECIP_WIDE = (64'd1 << SHIFT) / 64'(SLOTS);
   localparam logic [31:0] RECIP      = RECIP_WIDE[31:0];
   localparam logic [31:0] SLOTS_W    = 32'(SLOTS);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

   // Slot memory: valid bit over key
   logic [lpht_pkg::KEY_W:0]  slot_mem_ff [SLOTS];
   logic [lpht_pkg::KEY_W:0]  rd_data_ff;
   logic [IDX_W-1:0]          rd_addr;
   logic [IDX_W-1:0]          wr_addr;
   logic [lpht_pkg::KEY_W:0]  wr_data;
   logic                      wr_en;

   logic                      op_ff;
   logic [lpht_pkg::KEY_W-1:0] key_ff;
   logic [63:0]               prod_ff;
   logic [31:0]               qd_ff;
   logic [IDX_W-1:0]          cur_ff;
   logic [IDX_W-1:0]          cnt_ff;
   logic [IDX_W-1:0]          clr_cnt_ff;

   logic                      rsp_valid_ff;
   logic [1:0]                rsp_status_ff;
   logic [lpht_pkg::INDEX_W-1:0] rsp_index_ff;

   logic [63:0]               quot_wide;
   logic [31:0]               rem_raw;
   logic [31:0]               rem_fix;
   logic [IDX_W-1:0]          home;
   logic [IDX_W-1:0]          next_cur;
   logic                      entry_valid;
   logic                      hit;
   logic                      last_probe;
   logic                      is_insert;
   logic [1:0]                res_status;
   logic                      res_has_index;
   logic [IDX_W+lpht_pkg::INDEX_W-1:0] cur_wide;

   // Capture request beat
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         key_ff <= req_key;
      end
   end

   // Hash: multiply by reciprocal, then rebuild quotient times slot count
   assign quot_wide = prod_ff >> SHIFT;

   always_ff @(posedge clock) begin
      if (cmd.hash_mul) begin
         prod_ff <= 64'(key_ff) * 64'(RECIP);
      end
      if (cmd.hash_red) begin
         qd_ff <= 32'(quot_wide[31:0] * SLOTS_W);
      end
   end

   // Remainder is below twice the slot count: one corrective subtract
   assign rem_raw = key_ff - qd_ff;
   assign rem_fix = (rem_raw >= SLOTS_W) ? (rem_raw - SLOTS_W) : rem_raw;
   assign home    = rem_fix[IDX_W-1:0];

   // Advance probe pointer with wrap
   assign next_cur = (cur_ff == LAST_SLOT) ? '0 : cur_ff + IDX_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.probe_start) begin
         cur_ff <= home;
         cnt_ff <= '0;
      end else if (cmd.probe_step) begin
         cur_ff <= next_cur;
         cnt_ff <= cnt_ff + IDX_W'(1);
      end
   end

   // Step clear counter after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_we) begin
         clr_cnt_ff <= (clr_cnt_ff == LAST_SLOT) ? '0 : clr_cnt_ff + IDX_W'(1);
      end
   end

   // Judge the slot under the probe pointer
   assign entry_valid = rd_data_ff[lpht_pkg::KEY_W];
   assign hit         = entry_valid && (rd_data_ff[lpht_pkg::KEY_W-1:0] == key_ff);
   assign last_probe  = (cnt_ff == LAST_SLOT);
   assign is_insert   = (op_ff == lpht_pkg::OP_INSERT);

   always_comb begin
      if (is_insert) begin
         res_status    = entry_valid ? lpht_pkg::RSP_FULL : lpht_pkg::RSP_INSERTED;
         res_has_index = !entry_valid;
      end else begin
         res_status    = hit ? lpht_pkg::RSP_FOUND : lpht_pkg::RSP_NOT_FOUND;
         res_has_index = hit;
      end
   end

   assign sts.probe_end  = !entry_valid || last_probe || (!is_insert && hit);
   assign sts.clear_last = (clr_cnt_ff == LAST_SLOT);
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   // Memory port selection
   always_comb begin
      if (cmd.probe_start) begin
         rd_addr = home;
      end else if (cmd.probe_step) begin
         rd_addr = next_cur;
      end else begin
         rd_addr = cur_ff;
      end
   end

   assign wr_en   = cmd.clear_we || (cmd.finish && is_insert && !entry_valid);
   assign wr_addr = cmd.clear_we ? clr_cnt_ff : cur_ff;
   assign wr_data = cmd.clear_we ? '0 : {1'b1, key_ff};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem_ff[rd_addr];
   end

   // Load result beat, drop it once taken
   assign cur_wide = {{lpht_pkg::INDEX_W{1'b0}}, cur_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= res_status;
         rsp_index_ff  <= res_has_index ? cur_wide[lpht_pkg::INDEX_W-1:0] : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_index_ff;

endmodule

`default_nettype wire

/* rtl/linear_probe_hash_table.sv */
// ============================================================================
// linear_probe_hash_table
// Open-addressing hash table with linear probing over SLOTS key slots.
// ============================================================================
// Usage:
//   Request beats (req_opcode, req_key) enter on req_valid while req_stall is
//   low; insert stores the key in the first empty slot from key mod SLOTS,
//   search returns the first matching slot before an empty one.
//   Each request yields one response beat (rsp_status, rsp_slot_index).
//   Each request runs its hash steps (reciprocal multiply, quotient rebuild,
//   remainder and first slot read), then probes 1 to SLOTS slots in turn
//   through the read port of the slot memory; the response is registered
//   at the end of the walk. One request at a time: req_stall rises the
//   cycle after acceptance and stays high until the walk ends.
//   Reset: a clearing pass writes every slot empty with req_stall high.
//   A response held by rsp_stall stays stable; the next request may be taken
//   meanwhile, and its probe walk holds at its current slot until the
//   output register frees.
// ============================================================================
`default_nettype none

module linear_probe_hash_table #(
   parameter int SLOTS = lpht_pkg::SLOTS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_opcode,
   input  wire logic [lpht_pkg::KEY_W-1:0]    req_key,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic [lpht_pkg::INDEX_W-1:0]       rsp_slot_index
);

   lpht_pkg::cmd_type cmd;
   lpht_pkg::sts_type sts;

   // Sequencer
   lpht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Storage and arithmetic
   lpht_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_opcode     (req_opcode),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index)
   );

endmodule

`default_nettype wire

/* rtl/lpht_checker.sv */
// ============================================================================
// lpht_checker
// Port-level checks of the hash table, bound to the top level.
// ============================================================================
`default_nettype none

`include "linear_probe_hash_table_assert.svh"

module lpht_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [1:0]                    rsp_status,
   input wire logic [lpht_pkg::INDEX_W-1:0]  rsp_slot_index
);

   // Hold a stalled response beat
   `LPHT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_slot_index), "stalled response changed")

   // Only one request in flight
   `LPHT_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall, "request taken while busy")

   // No slot reported on a miss
   `LPHT_ASSERT_NOW(a_miss_index, clock, reset, rsp_valid && (rsp_status == lpht_pkg::RSP_FULL || rsp_status == lpht_pkg::RSP_NOT_FOUND), rsp_slot_index == '0, "slot index set on full or not found")

   // A new response comes out of a busy walk
   `LPHT_ASSERT_NOW(a_rsp_from_walk, clock, reset, $rose(rsp_valid), $past(req_stall), "response without a probe walk")

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_slot_index (rsp_slot_index)
);

`default_nettype wire

/* tb/linear_probe_hash_table_tb.sv */
// ============================================================================
// linear_probe_hash_table_tb
// Self-checking bench for the linear probing hash table. A shadow copy of
// the slot table predicts the status and slot of every accepted request,
// and each response beat is checked in order against that prediction.
// Stimulus is a short directed run (collisions, wraps, duplicates), then
// random inserts and searches and a forced fill, with random idling on both
// channels and one long response hold-off that backs up the request side.
// ============================================================================
`default_nettype none

module linear_probe_hash_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS         = lpht_pkg::SLOTS_DEFAULT;
   localparam int RANDOM_REQS   = 1110;
   localparam int QUIET_TAIL    = 150;
   localparam int HOLD_AT_REQ   = 300;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 2 * (SLOTS + 4);

   typedef struct {
      lpht_pkg::opcode_type                op;
      logic [lpht_pkg::KEY_W-1:0]          key;
   } table_request_type;

   typedef struct packed {
      lpht_pkg::rsp_status_type            status;
      logic [lpht_pkg::INDEX_W-1:0]        slot;
   } table_answer_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic                               req_opcode = lpht_pkg::OP_INSERT;
   logic [lpht_pkg::KEY_W-1:0]         req_key = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [1:0]                         rsp_status;
   logic [lpht_pkg::INDEX_W-1:0]       rsp_slot_index;

   // shadow copy of the slot table
   bit                                 shadow_used [SLOTS];
   logic [lpht_pkg::KEY_W-1:0]         shadow_key  [SLOTS];

   table_request_type                  queued_requests [$];
   table_answer_type                   expected_answers [$];

   int                  total_requests = 0;
   int                  accepted_count = 0;
   int                  answer_count = 0;
   int                  errors = 0;
   int                  status_seen [4] = '{0, 0, 0, 0};
   bit                  quiet_tail = 1'b0;
   int                  hold_left = 0;
   bit                  hold_done = 1'b0;
   int                  send_gap = 0;
   int                  stall_left = 0;

   linear_probe_hash_table #(
      .SLOTS(SLOTS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_key(req_key),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_slot_index(rsp_slot_index)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Apply one request to the shadow table and return its answer
   function automatic table_answer_type apply_to_shadow_table(
      lpht_pkg::opcode_type op, logic [lpht_pkg::KEY_W-1:0] key);
      int unsigned       s;
      table_answer_type  ans;
      s = key % SLOTS;
      ans.status = (op == lpht_pkg::OP_INSERT) ? lpht_pkg::RSP_FULL
                                               : lpht_pkg::RSP_NOT_FOUND;
      ans.slot   = '0;
      for (int n = 0; n < SLOTS; n++) begin
         if (op == lpht_pkg::OP_INSERT) begin
            if (!shadow_used[s]) begin
               shadow_used[s] = 1'b1;
               shadow_key[s]  = key;
               ans.status     = lpht_pkg::RSP_INSERTED;
               ans.slot       = s[lpht_pkg::INDEX_W-1:0];
               break;
            end
         end else begin
            // an empty slot ends the search
            if (!shadow_used[s])
               break;
            if (shadow_key[s] == key) begin
               ans.status = lpht_pkg::RSP_FOUND;
               ans.slot   = s[lpht_pkg::INDEX_W-1:0];
               break;
            end
         end
         s = (s + 1 == SLOTS) ? 0 : s + 1;
      end
      return ans;
   endfunction

   task automatic queue_request(lpht_pkg::opcode_type op,
                                logic [lpht_pkg::KEY_W-1:0] key);
      table_request_type r;
      r.op  = op;
      r.key = key;
      queued_requests.push_back(r);
   endtask

   // Key with random upper bits that lands on the same home slot as base
   function automatic logic [lpht_pkg::KEY_W-1:0] same_home_key(
      logic [lpht_pkg::KEY_W-1:0] base);
      logic [lpht_pkg::KEY_W-1:0] k;
      k = $urandom;
      return k - (k % SLOTS) + (base % SLOTS);
   endfunction

   // Build the request list: directed part, random part, forced fill
   task automatic build_requests();
      logic [lpht_pkg::KEY_W-1:0] stored_keys [$];
      logic [lpht_pkg::KEY_W-1:0] k;
      int                         pick;
      // empty table, then collisions, duplicates and wraps at the top slot
      queue_request(lpht_pkg::OP_SEARCH, 32'h0000_0000);
      queue_request(lpht_pkg::OP_INSERT, 32'h0000_0000);
      queue_request(lpht_pkg::OP_INSERT, 32'hFFFF_FFFF);
      queue_request(lpht_pkg::OP_INSERT, 32'h0000_0010);
      queue_request(lpht_pkg::OP_INSERT, 32'h0000_0010);
      queue_request(lpht_pkg::OP_SEARCH, 32'h0000_0010);
      queue_request(lpht_pkg::OP_SEARCH, 32'h0000_0000);
      queue_request(lpht_pkg::OP_SEARCH, 32'hFFFF_FFFF);
      queue_request(lpht_pkg::OP_SEARCH, 32'h0000_0020);
      queue_request(lpht_pkg::OP_INSERT, 32'h0000_001F);
      queue_request(lpht_pkg::OP_SEARCH, 32'h0000_001F);
      queue_request(lpht_pkg::OP_SEARCH, 32'h0000_002F);
      queue_request(lpht_pkg::OP_INSERT, 32'h8000_0000);
      queue_request(lpht_pkg::OP_SEARCH, 32'h8000_0000);
      queue_request(lpht_pkg::OP_SEARCH, 32'h7FFF_FFF0);
      stored_keys = {32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0010,
                     32'h0000_001F, 32'h8000_0000};
      // mostly searches, with rare inserts so the table fills slowly
      for (int i = 0; i < RANDOM_REQS; i++) begin
         pick = $urandom_range(0, stored_keys.size() - 1);
         if ($urandom_range(0, 99) < 3) begin
            k = ($urandom_range(0, 1) == 0) ? $urandom
                                            : same_home_key(stored_keys[pick]);
            stored_keys.push_back(k);
            queue_request(lpht_pkg::OP_INSERT, k);
         end else begin
            case ($urandom_range(0, 3)) inside
               0, 1: k = stored_keys[pick];
               2: k = same_home_key(stored_keys[pick]);
               default: k = $urandom;
            endcase
            queue_request(lpht_pkg::OP_SEARCH, k);
         end
      end
      // make sure the full-table insert and the full-wrap miss are reached
      for (int i = 0; i <= SLOTS; i++)
         queue_request(lpht_pkg::OP_INSERT, $urandom);
      queue_request(lpht_pkg::OP_SEARCH, same_home_key(32'h0000_0000));
      queue_request(lpht_pkg::OP_SEARCH, same_home_key(32'hFFFF_FFFF));
      total_requests = queued_requests.size();
   endtask

   // Request driver: predict each accepted beat, then offer the next one
   always @(posedge clock) begin
      table_request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_answers.push_back(
               apply_to_shadow_table(lpht_pkg::opcode_type'(req_opcode), req_key));
            accepted_count <= accepted_count + 1;
         end
         quiet_tail <= (queued_requests.size() <= QUIET_TAIL);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_valid <= 1'b0;
            end else if (queued_requests.size() == 0) begin
               req_valid <= 1'b0;
            end else if (!quiet_tail && ((accepted_count / 100) % 3 != 2) &&
                         $urandom_range(0, 4) == 0) begin
               send_gap = $urandom_range(1, 19) - 1;
               req_valid <= 1'b0;
            end else begin
               next_req = queued_requests.pop_front();
               req_valid  <= 1'b1;
               req_opcode <= next_req.op;
               req_key    <= next_req.key;
            end
         end
      end
   end

   // Long response hold-off once, so the block backs up its request side
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && accepted_count >= HOLD_AT_REQ) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Response monitor: check each beat, then drive the stall
   always @(posedge clock) begin
      table_answer_type exp_ans;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            answer_count <= answer_count + 1;
            if (expected_answers.size() == 0) begin
               errors++;
               $display("%0t: response with none expected: status %0d slot %0d",
                        $time, rsp_status, rsp_slot_index);
            end else begin
               exp_ans = expected_answers.pop_front();
               status_seen[exp_ans.status]++;
               if (rsp_status !== exp_ans.status) begin
                  errors++;
                  $display("%0t: status mismatch: expected %0d actual %0d",
                           $time, exp_ans.status, rsp_status);
               end
               if (rsp_slot_index !== exp_ans.slot) begin
                  errors++;
                  $display("%0t: slot_index mismatch: expected %0d actual %0d",
                           $time, exp_ans.slot, rsp_slot_index);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet_tail && ((answer_count / 100) % 3 != 1) &&
                      $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (hold_left != 0);
         end
      end
   end

   // Reset, run the stimulus, drain, report
   initial begin
      build_requests();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (accepted_count < total_requests || expected_answers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d requests over %0d slots: %0d inserted, %0d full,",
               total_requests, SLOTS, status_seen[lpht_pkg::RSP_INSERTED],
               status_seen[lpht_pkg::RSP_FULL]);
      $display("%0d found, %0d not found; %0d responses checked.",
               status_seen[lpht_pkg::RSP_FOUND], status_seen[lpht_pkg::RSP_NOT_FOUND],
               answer_count);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("%0t: timeout, %0d of %0d requests accepted, %0d answers pending",
               $time, accepted_count, total_requests, expected_answers.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
